// File: rtl/core/sha1sh_pkg.sv
package sha1sh_pkg;

  localparam logic [31:0] K0 = 32'h5A827999;
  localparam logic [31:0] K1 = 32'h6ED9EBA1;
  localparam logic [31:0] K2 = 32'h8F1BBCDC;
  localparam logic [31:0] K3 = 32'hCA62C1D6;

  localparam logic [31:0] H0 = 32'h67452301;
  localparam logic [31:0] H1 = 32'hEFCDAB89;
  localparam logic [31:0] H2 = 32'h98BADCFE;
  localparam logic [31:0] H3 = 32'h10325476;
  localparam logic [31:0] H4 = 32'hC3D2E1F0;

  localparam int unsigned NumWords = 5;
  localparam int unsigned NumRounds = 80;
  localparam logic [5:0] LenPos = 6'd56;
  localparam logic [7:0] PadByte = 8'h80;
  localparam logic [2:0] LastIdx = 3'd4;

  typedef enum logic [4:0] {
    StIdle  = 5'b00001,
    StPad   = 5'b00010,
    StRound = 5'b00100,
    StAdd   = 5'b01000,
    StOut   = 5'b10000
  } state_e;

  typedef logic [31:0] word_t;

  function automatic word_t init_word(input logic [2:0] idx);
    word_t r;
    unique case (idx)
      3'd0: r = H0;
      3'd1: r = H1;
      3'd2: r = H2;
      3'd3: r = H3;
      default: r = H4;
    endcase
    return r;
  endfunction

  function automatic word_t round_f(input logic [6:0] rnd, input word_t b, input word_t c,
                                    input word_t d);
    word_t r;
    priority if (rnd < 7'd20) begin
      r = (b & c) | (~b & d);
    end else if (rnd < 7'd40) begin
      r = b ^ c ^ d;
    end else if (rnd < 7'd60) begin
      r = (b & c) | (b & d) | (c & d);
    end else begin
      r = b ^ c ^ d;
    end
    return r;
  endfunction

  function automatic word_t round_k(input logic [6:0] rnd);
    word_t r;
    priority if (rnd < 7'd20) begin
      r = K0;
    end else if (rnd < 7'd40) begin
      r = K1;
    end else if (rnd < 7'd60) begin
      r = K2;
    end else begin
      r = K3;
    end
    return r;
  endfunction

endpackage

// File: rtl/core/sha1_stream_hash_unit.sv
// SHA-1 stream hasher, one message byte per input transaction.
// The byte that fills a block starts the compression, which runs one round per cycle through
// a single round adder.
// A finish transaction pads one byte per cycle and compresses once or twice, then
// presents five digest words, one per output transaction.
// Reset is asynchronous, active low, and loads the initial chaining values.
module sha1_stream_hash_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        mode_i,
  input  logic [7:0]  data_byte_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [31:0] digest_word_o,
  output logic [2:0]  word_index_o,
  output logic        last_word_o
);
  import sha1sh_pkg::*;

  state_e state_q, state_d;
  word_t chain_q [NumWords];
  word_t chain_d [NumWords];
  word_t a_q, b_q, c_q, d_q, e_q;
  word_t a_d, b_d, c_d, d_d, e_d;
  logic [511:0] buf_q, buf_d;
  logic [5:0] pos_q, pos_d;
  logic [63:0] bits_q, bits_d;
  logic [63:0] len_q, len_d;
  logic fin_q, fin_d;
  logic lenph_q, lenph_d;
  logic [6:0] rnd_q, rnd_d;
  logic [2:0] idx_q, idx_d;

  logic in_acc, out_acc, put_en;
  logic [7:0] put_byte;
  word_t w0, w_new, t_sum;

  assign in_stall_o = (state_q != StIdle);
  assign in_acc = in_valid_i && !in_stall_o;
  assign out_valid_o = (state_q == StOut);
  assign out_acc = out_valid_o && !out_stall_i;
  assign digest_word_o = chain_q[idx_q];
  assign word_index_o = idx_q;
  assign last_word_o = (idx_q == LastIdx);

  assign w0 = buf_q[511:480];
  assign w_new = {buf_q[511-32*13-1 -: 31] ^ buf_q[511-32*8-1 -: 31] ^
                  buf_q[511-32*2-1 -: 31] ^ buf_q[510:480],
                  buf_q[511-32*13] ^ buf_q[511-32*8] ^ buf_q[511-32*2] ^ buf_q[511]};
  assign t_sum = {a_q[26:0], a_q[31:27]} + round_f(rnd_q, b_q, c_q, d_q) + e_q +
                 round_k(rnd_q) + w0;

  always_comb begin
    state_d = state_q;
    chain_d = chain_q;
    a_d = a_q; b_d = b_q; c_d = c_q; d_d = d_q; e_d = e_q;
    buf_d = buf_q;
    pos_d = pos_q;
    bits_d = bits_q;
    len_d = len_q;
    fin_d = fin_q;
    lenph_d = lenph_q;
    rnd_d = rnd_q;
    idx_d = idx_q;
    put_en = 1'b0;
    put_byte = 8'h00;

    unique case (state_q)
      StIdle: begin
        if (in_acc) begin
          put_en = 1'b1;
          if (!mode_i) begin
            put_byte = data_byte_i;
            bits_d = bits_q + 64'd8;
          end else begin
            put_byte = PadByte;
            len_d = bits_q;
            fin_d = 1'b1;
            lenph_d = 1'b0;
            state_d = StPad;
          end
        end
      end
      StPad: begin
        put_en = 1'b1;
        if (lenph_q || (pos_q == LenPos)) begin
          put_byte = len_q[63:56];
          len_d = {len_q[55:0], 8'h00};
          lenph_d = 1'b1;
        end
      end
      StRound: begin
        e_d = d_q;
        d_d = c_q;
        c_d = {b_q[1:0], b_q[31:2]};
        b_d = a_q;
        a_d = t_sum;
        buf_d = {buf_q[479:0], w_new};
        rnd_d = rnd_q + 7'd1;
        if (rnd_q == 7'(NumRounds - 1)) begin
          state_d = StAdd;
        end
      end
      StAdd: begin
        chain_d[0] = chain_q[0] + a_q;
        chain_d[1] = chain_q[1] + b_q;
        chain_d[2] = chain_q[2] + c_q;
        chain_d[3] = chain_q[3] + d_q;
        chain_d[4] = chain_q[4] + e_q;
        priority if (fin_q && lenph_q) begin
          state_d = StOut;
          idx_d = 3'd0;
        end else if (fin_q) begin
          state_d = StPad;
        end else begin
          state_d = StIdle;
        end
      end
      StOut: begin
        if (out_acc) begin
          idx_d = idx_q + 3'd1;
          if (idx_q == LastIdx) begin
            for (int i = 0; i < NumWords; i++) begin
              chain_d[i] = init_word(3'(i));
            end
            idx_d = 3'd0;
            pos_d = 6'd0;
            bits_d = 64'd0;
            fin_d = 1'b0;
            lenph_d = 1'b0;
            state_d = StIdle;
          end
        end
      end
      default: state_d = StIdle;
    endcase

    if (put_en) begin
      buf_d = {buf_q[503:0], put_byte};
      pos_d = pos_q + 6'd1;
      if (pos_q == 6'd63) begin
        state_d = StRound;
        rnd_d = 7'd0;
        a_d = chain_q[0];
        b_d = chain_q[1];
        c_d = chain_q[2];
        d_d = chain_q[3];
        e_d = chain_q[4];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      for (int i = 0; i < NumWords; i++) begin
        chain_q[i] <= init_word(3'(i));
      end
      pos_q <= 6'd0;
      bits_q <= 64'd0;
      fin_q <= 1'b0;
      lenph_q <= 1'b0;
      rnd_q <= 7'd0;
      idx_q <= 3'd0;
    end else begin
      state_q <= state_d;
      chain_q <= chain_d;
      pos_q <= pos_d;
      bits_q <= bits_d;
      fin_q <= fin_d;
      lenph_q <= lenph_d;
      rnd_q <= rnd_d;
      idx_q <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    buf_q <= buf_d;
    len_q <= len_d;
    a_q <= a_d;
    b_q <= b_d;
    c_q <= c_d;
    d_q <= d_d;
    e_q <= e_d;
  end

  a_state_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni) $onehot(state_q))
    else $error("State register is not one-hot.");
  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_stall_o |-> !out_valid_o)
    else $error("Input taken while a digest is pending.");
  a_round_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StRound) |-> (rnd_q < 7'(NumRounds)))
    else $error("Round counter out of range.");
  a_last_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_acc && last_word_o) |=> (state_q == StIdle) && (pos_q == 6'd0))
    else $error("State not cleared after the last digest word.");
  a_out_from_add: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> ($past(state_q) == StAdd) && (idx_q == 3'd0))
    else $error("Digest output started without a final compression.");

endmodule

// File: tb/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import sha1sh_pkg::*;

  localparam int unsigned StallLimit = 20000;
  localparam bit ModeAbsorb = 1'b0;
  localparam bit ModeFinish = 1'b1;

  typedef struct packed {
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;
  } digest_beat_t;

  typedef struct packed {
    logic       mode;
    logic [7:0] data_byte;
    logic       has_digest;
    logic [31:0] digest0;
  } stim_row_t;

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_stall_o;
  logic        mode_i;
  logic [7:0]  data_byte_i;
  logic        out_valid_o;
  logic        out_stall_i;
  logic [31:0] digest_word_o;
  logic [2:0]  word_index_o;
  logic        last_word_o;

  sha1_stream_hash_unit uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .mode_i       (mode_i),
    .data_byte_i  (data_byte_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .digest_word_o(digest_word_o),
    .word_index_o (word_index_o),
    .last_word_o  (last_word_o)
  );

  word_t        sha_chain[5];
  logic [7:0]   sha_block[64];
  int unsigned  sha_pos;
  logic [63:0]  sha_bits;
  digest_beat_t pending_digest[$];
  int unsigned  error_count;
  int unsigned  sender_idle_pct;
  int unsigned  receiver_idle_pct;
  int unsigned  hold_off_cycles;
  int unsigned  quiet_cycles;
  stim_row_t    rows[$];

  always begin
    clk_i = 1'b1;
    #1;
    clk_i = 1'b0;
    #1;
  end

  function automatic word_t rotl(input word_t v, input int unsigned n);
    return (v << n) | (v >> (32 - n));
  endfunction

  task automatic sha_reset();
    sha_chain[0] = H0;
    sha_chain[1] = H1;
    sha_chain[2] = H2;
    sha_chain[3] = H3;
    sha_chain[4] = H4;
    sha_pos = 0;
    sha_bits = '0;
  endtask

  task automatic sha_compress();
    word_t w[80];
    word_t a, b, c, d, e, f, k, t;
    for (int i = 0; i < 16; i++) begin
      w[i] = {sha_block[4*i], sha_block[4*i+1], sha_block[4*i+2], sha_block[4*i+3]};
    end
    for (int i = 16; i < 80; i++) begin
      w[i] = rotl(w[i-3] ^ w[i-8] ^ w[i-14] ^ w[i-16], 1);
    end
    a = sha_chain[0];
    b = sha_chain[1];
    c = sha_chain[2];
    d = sha_chain[3];
    e = sha_chain[4];
    for (int i = 0; i < 80; i++) begin
      if (i < 20) begin
        f = (b & c) | (~b & d);
        k = 32'h5A827999;
      end else if (i < 40) begin
        f = b ^ c ^ d;
        k = 32'h6ED9EBA1;
      end else if (i < 60) begin
        f = (b & c) | (b & d) | (c & d);
        k = 32'h8F1BBCDC;
      end else begin
        f = b ^ c ^ d;
        k = 32'hCA62C1D6;
      end
      t = rotl(a, 5) + f + e + k + w[i];
      e = d;
      d = c;
      c = rotl(b, 30);
      b = a;
      a = t;
    end
    sha_chain[0] += a;
    sha_chain[1] += b;
    sha_chain[2] += c;
    sha_chain[3] += d;
    sha_chain[4] += e;
  endtask

  task automatic sha_put(input logic [7:0] v);
    sha_block[sha_pos] = v;
    sha_pos = (sha_pos + 1) % 64;
    if (sha_pos == 0) begin
      sha_compress();
    end
  endtask

  task automatic predict_digest(input logic mode, input logic [7:0] data);
    logic [63:0] len;
    digest_beat_t beat;
    if (mode == ModeAbsorb) begin
      sha_put(data);
      sha_bits += 64'd8;
    end else begin
      len = sha_bits;
      sha_put(PadByte);
      while (sha_pos != 56) begin
        sha_put(8'h00);
      end
      for (int i = 0; i < 8; i++) begin
        sha_put(len[63 - 8*i -: 8]);
      end
      for (int i = 0; i < 5; i++) begin
        beat.digest_word = sha_chain[i];
        beat.word_index = 3'(i);
        beat.last_word = (i == 4);
        pending_digest.push_back(beat);
      end
      sha_reset();
    end
  endtask

  task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
    $display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
    error_count++;
  endtask

  always @(posedge clk_i) begin
    digest_beat_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_digest.size() == 0) begin
        report("unexpected digest word", digest_word_o, 32'h0);
      end else begin
        want = pending_digest.pop_front();
        if (digest_word_o !== want.digest_word) begin
          report("digest_word", digest_word_o, want.digest_word);
        end
        if (word_index_o !== want.word_index) begin
          report("word_index", 32'(word_index_o), 32'(want.word_index));
        end
        if (last_word_o !== want.last_word) begin
          report("last_word", 32'(last_word_o), 32'(want.last_word));
        end
      end
    end
  end

  // The receiver stalls at random, or holds off completely for a counted stretch.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else if (hold_off_cycles != 0) begin
      hold_off_cycles <= hold_off_cycles - 1;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= ($urandom_range(99) < receiver_idle_pct);
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= StallLimit) begin
        $display("sha1_stream_hash_unit regression: fail");
        $finish;
      end
    end
  end

  task automatic send_item(input logic mode, input logic [7:0] data);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    mode_i <= mode;
    data_byte_i <= data;
    predict_digest(mode, data);
    do begin
      @(posedge clk_i);
    end while (in_stall_o);
  endtask

  task automatic send_message(input int unsigned len);
    for (int i = 0; i < len; i++) begin
      send_item(ModeAbsorb, 8'($urandom));
    end
    send_item(ModeFinish, 8'($urandom));
  endtask

  task automatic add_row(input logic mode, input logic [7:0] data, input logic chk,
                         input logic [31:0] d0);
    stim_row_t r;
    r.mode = mode;
    r.data_byte = data;
    r.has_digest = chk;
    r.digest0 = d0;
    rows.push_back(r);
  endtask

  initial begin
    int unsigned len;
    int unsigned tail;
    int unsigned bound_lens[4];
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    mode_i = 1'b0;
    data_byte_i = 8'h00;
    out_stall_i = 1'b0;
    error_count = 0;
    hold_off_cycles = 0;
    quiet_cycles = 0;
    sender_idle_pct = 25;
    receiver_idle_pct = 65;
    sha_reset();
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Empty message, "abc", a repeated finish, and byte extremes with a spare data bit set.
    add_row(ModeFinish, 8'h00, 1'b1, 32'hDA39A3EE);
    add_row(ModeAbsorb, 8'h61, 1'b0, 32'h0);
    add_row(ModeAbsorb, 8'h62, 1'b0, 32'h0);
    add_row(ModeAbsorb, 8'h63, 1'b0, 32'h0);
    add_row(ModeFinish, 8'hFF, 1'b1, 32'hA9993E36);
    add_row(ModeFinish, 8'h55, 1'b1, 32'hDA39A3EE);
    add_row(ModeAbsorb, 8'hFF, 1'b0, 32'h0);
    add_row(ModeAbsorb, 8'h00, 1'b0, 32'h0);
    add_row(ModeAbsorb, 8'hAA, 1'b0, 32'h0);
    add_row(ModeFinish, 8'h00, 1'b0, 32'h0);
    foreach (rows[i]) begin
      send_item(rows[i].mode, rows[i].data_byte);
      if (rows[i].has_digest && pending_digest.size() == 5 &&
          pending_digest[0].digest_word !== rows[i].digest0) begin
        report("directed first digest word", pending_digest[0].digest_word, rows[i].digest0);
      end
    end

    // Lengths around the padding boundaries, then random messages.
    bound_lens = '{55, 56, 63, 64};
    foreach (bound_lens[i]) begin
      send_message(bound_lens[i]);
      if (i == 1) begin
        sender_idle_pct = 65;
        receiver_idle_pct = 25;
      end
    end
    hold_off_cycles = 1500;
    send_message(8);
    for (int m = 0; m < 6; m++) begin
      len = $urandom_range(0, 6);
      if (m >= 3) begin
        sender_idle_pct = 0;
        receiver_idle_pct = 0;
      end
      send_message(len);
    end
    in_valid_i <= 1'b0;

    tail = 0;
    while (pending_digest.size() != 0) begin
      @(posedge clk_i);
    end
    while (tail < 300) begin
      @(posedge clk_i);
      tail++;
    end
    if (error_count == 0) begin
      $display("sha1_stream_hash_unit regression: pass");
    end else begin
      $display("sha1_stream_hash_unit regression: fail");
    end
    $finish;
  end

endmodule
